FILE: rtl/core/pvs_pkg.sv
// Shared types and constants for the page victim selector.
// Holds the beat payloads, the policy codes, the sequencer states and the key select.
// No dependencies.
package pvs_pkg;

	localparam int FRAME_W = 7;
	localparam int KEY_W   = 32;
	// RAM entry: page_valid, last_access, load_time, use_count (msb to lsb)
	localparam int ENTRY_W = 1 + 3 * KEY_W;
	localparam logic [KEY_W-1:0] KEY_UNSET = '1;

	typedef enum logic [1:0] {
		POL_LRU  = 2'd0,
		POL_FIFO = 2'd1,
		POL_LFU  = 2'd2,
		POL_MFU  = 2'd3
	} policy_mode_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_FIND  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} pvs_state_t;

	typedef struct packed {
		logic                    opcode;
		logic [FRAME_W-1:0]      frame_index;
		logic                    occupied;
		logic                    page_valid;
		logic signed [KEY_W-1:0] last_access;
		logic signed [KEY_W-1:0] load_time;
		logic signed [KEY_W-1:0] use_count;
	} in_item_t;

	typedef struct packed {
		logic [FRAME_W-1:0] victim_frame;
		logic               victim_found;
	} out_item_t;

	// sequencer to compare unit
	typedef struct packed {
		logic         clear;
		logic         step;
		logic         occ;
		policy_mode_t policy;
	} pvs_scan_ctl_t;

	function automatic logic [ENTRY_W-1:0] pack_entry(input in_item_t it);
		return {it.page_valid, it.last_access, it.load_time, it.use_count};
	endfunction

	function automatic logic [KEY_W-1:0] key_sel(input logic [ENTRY_W-1:0] e,
			input policy_mode_t pol);
		logic [KEY_W-1:0] k;
		unique case (pol)
			POL_LRU:  k = e[3*KEY_W-1:2*KEY_W];
			POL_FIFO: k = e[2*KEY_W-1:KEY_W];
			default:  k = e[KEY_W-1:0];
		endcase
		return k;
	endfunction

endpackage

FILE: rtl/core/pvs_stream_if.sv
// Valid/ready channel carrying one beat of type T.
// Used for the request and response channels; no dependencies.
interface pvs_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/pvs_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module pvs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [AW-1:0]            raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: rtl/core/pvs_scan.sv
// Shared compare unit: takes one frame per step and keeps the running victim.
// Depends on pvs_pkg.
module pvs_scan #(
	parameter int AW = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pvs_pkg::pvs_scan_ctl_t      ctl,
	input  logic [AW-1:0]               idx,
	input  logic [pvs_pkg::ENTRY_W-1:0] entry,
	output pvs_pkg::out_item_t          res
);
	import pvs_pkg::*;

	logic              have_q, have_set_q, have_occ_q;
	logic [AW-1:0]     pick_q, first_q;
	logic [KEY_W-1:0]  best_q;
	logic [KEY_W-1:0]  key;
	logic              eligible, key_set, better;

	assign key      = key_sel(entry, ctl.policy);
	assign eligible = ctl.occ && entry[ENTRY_W-1];
	assign key_set  = (key != KEY_UNSET);
	assign better   = (ctl.policy == POL_MFU) ? ($signed(key) > $signed(best_q))
	                                          : ($signed(key) < $signed(best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q     <= 1'b0;
			have_set_q <= 1'b0;
			have_occ_q <= 1'b0;
		end else if (ctl.clear) begin
			have_q     <= 1'b0;
			have_set_q <= 1'b0;
			have_occ_q <= 1'b0;
		end else if (ctl.step) begin
			if (ctl.occ) begin
				have_occ_q <= 1'b1;
			end
			if (eligible && key_set && (!have_set_q || better)) begin
				have_q     <= 1'b1;
				have_set_q <= 1'b1;
			end else if (eligible && !key_set && !have_q) begin
				have_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			if (ctl.occ && !have_occ_q) begin
				first_q <= idx;
			end
			if (eligible && key_set && (!have_set_q || better)) begin
				pick_q <= idx;
				best_q <= key;
			end else if (eligible && !key_set && !have_q) begin
				pick_q <= idx;
			end
		end
	end

	// fall back to the first occupied frame when nothing eligible was seen
	always_comb begin
		res.victim_found = have_q || have_occ_q;
		if (have_q) begin
			res.victim_frame = FRAME_W'(32'(pick_q));
		end else if (have_occ_q) begin
			res.victim_frame = FRAME_W'(32'(first_q));
		end else begin
			res.victim_frame = '0;
		end
	end
endmodule

FILE: rtl/core/page_victim_selector_core.sv
// Top level of the page victim selector: frame table, scan sequencer, response register.
// Depends on pvs_pkg, pvs_stream_if, pvs_ram and pvs_scan.
//
// Usage
//   req carries one beat per request. A write beat (opcode 0) loads one frame entry
//   and gives no response; an index at or above NUM_FRAMES is dropped.
//   A find beat (opcode 1) scans the whole frame table and gives one response beat on
//   rsp with the victim frame and a found flag.
//   A find passes through the scan, drain and final states on its way to the response
//   register: the frame RAM gives one entry per cycle to the single compare unit through
//   its registered read, and the final state loads the response. req.ready is low from
//   acceptance until the find leaves the final state, so a new beat waits for the last find.
//   cfg_we/cfg_wdata write the replacement policy; write it only while idle.
//   Reset clears the occupied flags (all frames free), the policy (least recent
//   access) and the response valid flag; the rest of the table holds whatever was
//   last written.
//   The response register lets the next beat be accepted while a response waits. If
//   rsp stalls and a second find completes, that find holds in its final state until
//   the pending beat is taken.
module page_victim_selector_core #(
	parameter int NUM_FRAMES = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_wdata,
	pvs_stream_if.sink          req,
	pvs_stream_if.source        rsp
);
	import pvs_pkg::*;

	localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

	pvs_state_t            state_q, state_d;
	policy_mode_t          policy_q;
	logic [NUM_FRAMES-1:0] occ_q;
	logic [AW-1:0]         cnt_q;
	logic                  valid_s1, occ_s1;
	logic [AW-1:0]         idx_s1;
	logic                  rsp_valid_q;
	out_item_t             rsp_data_q;

	in_item_t              item;
	logic                  req_fire, wr_fire, find_fire, wr_in_range;
	logic [AW-1:0]         wr_addr;
	logic                  cnt_last, rsp_free;
	logic [ENTRY_W-1:0]    rd_entry;
	pvs_scan_ctl_t         scan_ctl;
	out_item_t             scan_res;

	assign item        = req.data;
	assign req.ready   = (state_q == ST_IDLE);
	assign req_fire    = req.valid && req.ready;
	assign wr_fire     = req_fire && (item.opcode == OP_WRITE);
	assign find_fire   = req_fire && (item.opcode == OP_FIND);
	assign wr_in_range = (32'(item.frame_index) < NUM_FRAMES);
	assign wr_addr     = AW'(32'(item.frame_index));
	assign cnt_last    = (cnt_q == AW'(NUM_FRAMES - 1));
	assign rsp_free    = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_LRU;
		end else if (cfg_we) begin
			policy_q <= policy_mode_t'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (wr_fire && wr_in_range) begin
			occ_q[wr_addr] <= item.occupied;
		end
	end

	pvs_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_FRAMES)
	) u_frame_ram (
		.clk   (clk),
		.we    (wr_fire && wr_in_range),
		.waddr (wr_addr),
		.wdata (pack_entry(item)),
		.raddr (cnt_q),
		.rdata (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (find_fire) state_d = ST_SCAN;
			ST_SCAN:  if (cnt_last) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE:  if (rsp_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// read address counter; the occupied flag rides along with the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_SCAN) begin
				cnt_q <= cnt_last ? '0 : cnt_q + AW'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		occ_s1 <= occ_q[cnt_q];
	end

	assign scan_ctl.clear  = find_fire;
	assign scan_ctl.step   = valid_s1;
	assign scan_ctl.occ    = occ_s1;
	assign scan_ctl.policy = policy_q;

	pvs_scan #(
		.AW (AW)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.idx    (idx_s1),
		.entry  (rd_entry),
		.res    (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && rsp_free) begin
			rsp_data_q <= scan_res;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

`ifndef SYNTHESIS
	a_step_follows_scan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(state_q == ST_SCAN))
		else $error("compare step without a scan read");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
		else $error("response raised outside the final state");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_data_q.victim_found) |-> (rsp_data_q.victim_frame == '0))
		else $error("frame not zero on a not-found response");

	a_table_stable_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> $stable(occ_q))
		else $error("occupied flags changed during a scan");
`endif
endmodule

FILE: dv/tb.sv
// Testbench for page_victim_selector_core: random and directed frame writes and victim finds.
// A queue-fed driver and a response monitor check every find beat against an in-bench predictor.
// Depends on pvs_pkg, pvs_stream_if and the core RTL.
`timescale 1ns / 1ps

module tb;
	import pvs_pkg::*;

	localparam int NUM_FRAMES  = 128;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASE_BEATS = 204;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_wdata;

	pvs_stream_if #(.T(in_item_t))  req_if ();
	pvs_stream_if #(.T(out_item_t)) rsp_if ();

	page_victim_selector_core #(
		.NUM_FRAMES(NUM_FRAMES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_if),
		.rsp      (rsp_if)
	);

	// frame table as the predictor sees it
	bit                      tbl_occ    [NUM_FRAMES];
	bit                      tbl_valid  [NUM_FRAMES];
	logic signed [KEY_W-1:0] tbl_access [NUM_FRAMES];
	logic signed [KEY_W-1:0] tbl_loaded [NUM_FRAMES];
	logic signed [KEY_W-1:0] tbl_uses   [NUM_FRAMES];
	policy_mode_t            cur_policy;

	in_item_t  pending_reqs [$];
	out_item_t victim_q     [$];

	bit idle_en;
	int req_gap;
	int rsp_stall;
	int n_err;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic signed [KEY_W-1:0] policy_key(input int f);
		case (cur_policy)
			POL_LRU:  return tbl_access[f];
			POL_FIFO: return tbl_loaded[f];
			default:  return tbl_uses[f];
		endcase
	endfunction

	function automatic out_item_t pick_victim();
		out_item_t               res;
		bit                      have;
		bit                      have_set;
		bit                      want_max;
		int                      pick;
		logic signed [KEY_W-1:0] best;
		logic signed [KEY_W-1:0] k;
		have     = 1'b0;
		have_set = 1'b0;
		pick     = 0;
		best     = '0;
		want_max = (cur_policy == POL_MFU);
		for (int f = 0; f < NUM_FRAMES; f++) begin
			if (!tbl_occ[f] || !tbl_valid[f])
				continue;
			k = policy_key(f);
			if (k != KEY_UNSET) begin
				if (!have_set || (want_max ? (k > best) : (k < best))) begin
					pick     = f;
					best     = k;
					have_set = 1'b1;
					have     = 1'b1;
				end
			end else if (!have) begin
				pick = f;
				have = 1'b1;
			end
		end
		// nothing eligible: fall back to the first occupied frame
		if (!have) begin
			for (int f = 0; f < NUM_FRAMES; f++) begin
				if (tbl_occ[f]) begin
					pick = f;
					have = 1'b1;
					break;
				end
			end
		end
		res.victim_frame = have ? pick[FRAME_W-1:0] : '0;
		res.victim_found = have;
		return res;
	endfunction

	task automatic note_request(input in_item_t it);
		int idx;
		idx = it.frame_index;
		if (it.opcode == OP_WRITE) begin
			if (idx < NUM_FRAMES) begin
				tbl_occ[idx]    = it.occupied;
				tbl_valid[idx]  = it.page_valid;
				tbl_access[idx] = it.last_access;
				tbl_loaded[idx] = it.load_time;
				tbl_uses[idx]   = it.use_count;
			end
		end else begin
			victim_q.insert(victim_q.size(), pick_victim());
		end
	endtask

	task automatic queue_beat(input in_item_t it);
		pending_reqs.insert(pending_reqs.size(), it);
	endtask

	task automatic flag_error(input string msg);
		n_err++;
		if (n_err <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_if.valid && req_if.ready)
				note_request(req_if.data);
			if (!req_if.valid || req_if.ready) begin
				if (req_gap != 0) begin
					req_gap--;
					req_if.valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					req_if.data  <= pending_reqs.pop_front();
					req_if.valid <= 1'b1;
					if (idle_en && $urandom_range(0, 5) == 0)
						req_gap = $urandom_range(1, 18);
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor and back-pressure
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (victim_q.size() == 0) begin
					flag_error($sformatf("response beat with none outstanding: frame %0d found %0b",
						rsp_if.data.victim_frame, rsp_if.data.victim_found));
				end else begin
					want = victim_q.pop_front();
					if (rsp_if.data.victim_frame !== want.victim_frame)
						flag_error($sformatf("victim_frame mismatch: expected %0d, got %0d",
							want.victim_frame, rsp_if.data.victim_frame));
					if (rsp_if.data.victim_found !== want.victim_found)
						flag_error($sformatf("victim_found mismatch: expected %0b, got %0b",
							want.victim_found, rsp_if.data.victim_found));
				end
			end
			if (rsp_stall != 0) begin
				rsp_stall--;
				rsp_if.ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				rsp_stall = $urandom_range(0, 17);
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic in_item_t frame_write(input int idx, input bit occ, input bit pv,
			input logic signed [KEY_W-1:0] acc, input logic signed [KEY_W-1:0] ld,
			input logic signed [KEY_W-1:0] uses);
		in_item_t it;
		it.opcode      = OP_WRITE;
		it.frame_index = idx[FRAME_W-1:0];
		it.occupied    = occ;
		it.page_valid  = pv;
		it.last_access = acc;
		it.load_time   = ld;
		it.use_count   = uses;
		return it;
	endfunction

	function automatic in_item_t find_req();
		in_item_t it;
		it        = '0;
		it.opcode = OP_FIND;
		return it;
	endfunction

	// biased towards ties, unset keys and the ends of the range
	function automatic logic signed [KEY_W-1:0] rand_key();
		case ($urandom_range(0, 9))
			0, 1:    return KEY_UNSET;
			2:       return 32'sh7fff_ffff;
			3:       return '0;
			4, 5, 6: return $urandom_range(0, 15);
			default: return $urandom & 32'h7fff_ffff;
		endcase
	endfunction

	function automatic in_item_t rand_request();
		in_item_t it;
		it = frame_write($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 127),
			$urandom_range(0, 9) != 0, $urandom_range(0, 4) != 0,
			rand_key(), rand_key(), rand_key());
		// find beats carry random junk in the unused fields
		if ($urandom_range(0, 99) < 35)
			it.opcode = OP_FIND;
		return it;
	endfunction

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || req_if.valid || victim_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_policy(input policy_mode_t pol);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= pol;
		@(posedge clk);
		cfg_we     <= 1'b0;
		cur_policy = pol;
	endtask

	initial begin
		policy_mode_t order [8];
		order = '{POL_FIFO, POL_LFU, POL_MFU, POL_LRU, POL_MFU, POL_FIFO, POL_LFU, POL_LRU};
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		rsp_if.ready = 1'b0;
		cur_policy   = POL_LRU;
		idle_en      = 1'b1;
		req_gap      = 0;
		rsp_stall    = 0;
		n_err        = 0;
		cycles       = 0;
		for (int f = 0; f < NUM_FRAMES; f++) begin
			tbl_occ[f]    = 1'b0;
			tbl_valid[f]  = 1'b0;
			tbl_access[f] = '0;
			tbl_loaded[f] = '0;
			tbl_uses[f]   = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		set_policy(POL_LRU);

		// directed: empty table, fallback, unset vs set keys, ties, free and invalid frames
		queue_beat(find_req());
		queue_beat(frame_write(0, 1'b1, 1'b0, 7, 7, 7));
		queue_beat(find_req());
		queue_beat(frame_write(127, 1'b1, 1'b1, KEY_UNSET, KEY_UNSET, KEY_UNSET));
		queue_beat(find_req());
		queue_beat(frame_write(5, 1'b1, 1'b1, 32'sh7fff_ffff, 32'sh7fff_ffff,
			32'sh7fff_ffff));
		queue_beat(find_req());
		queue_beat(frame_write(64, 1'b1, 1'b1, 0, 0, 0));
		queue_beat(find_req());
		queue_beat(frame_write(3, 1'b1, 1'b1, 0, KEY_UNSET, 9));
		queue_beat(find_req());
		queue_beat(frame_write(3, 1'b0, 1'b1, 0, 0, 0));
		queue_beat(find_req());
		queue_beat(frame_write(64, 1'b1, 1'b0, 0, 0, 0));
		queue_beat(find_req());
		queue_beat(frame_write(127, 1'b1, 1'b1, 1, 2, 3));
		queue_beat(find_req());
		wait_drained();

		for (int p = 0; p < $size(order); p++) begin
			set_policy(order[p]);
			// quiet run-out: no gaps or stalls in the final stretch
			if (p == $size(order) - 1)
				idle_en = 1'b0;
			for (int i = 0; i < PHASE_BEATS; i++)
				queue_beat(rand_request());
			wait_drained();
		end

		repeat (NUM_FRAMES + 8) @(posedge clk);
		if (n_err == 0 && victim_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
